// ===== rtl/sefd_pkg.sv =====
// shared types and constants for the sync/escape frame decoder
// no dependencies; used by every rtl file through scoped names
`default_nettype none

package sefd_pkg;

	// framing bytes
	localparam logic [7:0] SYNC_BYTE  = 8'hE0;
	localparam logic [7:0] ESC_BYTE   = 8'hD0;
	localparam logic [8:0] HEADER_LEN = 9'd3;

	// default depth of the result queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam logic CFG_CHECKSUM_STRICT = 1'b0;
	localparam logic CFG_SYNC_HUNT       = 1'b1;

	// result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_WARN   = 3'd1,
		ST_REJECT = 3'd2,
		ST_STRAY  = 3'd3,
		ST_NOSYNC = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_DATA   = 4'b0100,
		PH_CHECK  = 4'b1000
	} phase_t;

	// one result item
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic [8:0] position;
		status_t    status;
		logic [7:0] sum_value;
	} res_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sync_escape_frame_decoder.sv =====
// sync/escape frame decoder: top level joining front, queue and back
// depends on sefd_pkg, sefd_front, sefd_queue, sefd_back
//
// usage
//  - input channel: one raw serial byte per item on rx_byte, valid/ready
//  - output channel: zero or one result item per input byte; kind 0 is a
//    decoded frame byte with its position and running sum, kind 1 closes the
//    frame (checksum ok, warned, rejected) or reports a stray sync or no sync
//  - config port: cfg_we/cfg_index/cfg_data, index 0 checksum_strict,
//    index 1 sync_hunt; write only while the block is idle
//  - throughput: one byte per cycle sustained while the queue has room;
//    frame state update: compare, 8-bit adds, counter step in the front stage
//  - path: a result item goes through the queue and the output register
//    before it shows on out_valid; the front writes the queue when it
//    accepts the byte, the back loads the register once it is free
//  - stall: the front keeps accepting while the output is stalled until the
//    QueueDepth-entry queue fills; in_ready then drops until the receiver
//    takes an item
//  - reset: arst_n clears frame state to hunting, empties the queue and
//    clears out_valid; checksum_strict resets to 0 and sync_hunt to 1
`default_nettype none

module sync_escape_frame_decoder #(
	parameter int unsigned QueueDepth = sefd_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	// input byte channel
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  wire         out_ready,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [8:0]  position,
	output logic [2:0]  status,
	output logic [7:0]  sum_value,
	// configuration writes
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire         cfg_data
);

	sefd_pkg::q_stat_t q_stat;
	sefd_pkg::res_t    push_res;
	sefd_pkg::res_t    head;
	sefd_pkg::res_t    out_res;
	logic              push;
	logic              pop;

	// front: frame state machine and classification of each byte
	sefd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_res (push_res)
	);

	// queue decouples front from output stalls
	sefd_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_res(push_res),
		.pop     (pop),
		.head    (head),
		.q_stat  (q_stat)
	);

	// back: output register toward the receiver
	sefd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	assign kind      = out_res.kind;
	assign data_byte = out_res.data_byte;
	assign position  = out_res.position;
	assign status    = out_res.status;
	assign sum_value = out_res.sum_value;

endmodule

`default_nettype wire

// ===== rtl/sefd_front.sv =====
// front part: accepts raw bytes, tracks frame state and classifies each byte
// depends on sefd_pkg
`default_nettype none

module sefd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          rx_byte,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire                 cfg_data,
	input  sefd_pkg::q_stat_t   q_stat,
	output logic                push,
	output sefd_pkg::res_t      push_res
);

	logic              strict_q;
	logic              hunt_q;
	sefd_pkg::phase_t  phase_q, phase_d;
	logic [8:0]        count_q, count_d;
	logic [7:0]        remaining_q, remaining_d;
	logic [7:0]        sum_q, sum_d;
	logic              esc_q, esc_d;
	logic              res_valid;
	logic              accept;
	logic [7:0]        dec;
	logic [7:0]        sum_new;
	logic [8:0]        count_new;
	logic [7:0]        rem_dec;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && res_valid;

	assign dec       = esc_q ? (rx_byte + 8'd1) : rx_byte;
	assign sum_new   = sum_q + dec;
	assign count_new = count_q + 9'd1;
	assign rem_dec   = remaining_q - 8'd1;

	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		remaining_d = remaining_q;
		sum_d       = sum_q;
		esc_d       = esc_q;
		res_valid   = 1'b0;
		push_res.kind      = sefd_pkg::KIND_STATUS;
		push_res.data_byte = rx_byte;
		push_res.position  = count_q;
		push_res.status    = sefd_pkg::ST_OK;
		push_res.sum_value = sum_q;
		unique case (phase_q)
			sefd_pkg::PH_HUNT: begin
				if (rx_byte == sefd_pkg::SYNC_BYTE) begin
					phase_d = sefd_pkg::PH_HEADER;
				end else if (!hunt_q) begin
					res_valid          = 1'b1;
					push_res.position  = 9'd0;
					push_res.sum_value = 8'd0;
					push_res.status    = sefd_pkg::ST_NOSYNC;
				end
			end
			sefd_pkg::PH_CHECK: begin
				res_valid = 1'b1;
				if (rx_byte != sum_q) begin
					push_res.status = strict_q ? sefd_pkg::ST_REJECT : sefd_pkg::ST_WARN;
				end
				phase_d     = sefd_pkg::PH_HUNT;
				count_d     = '0;
				remaining_d = '0;
				sum_d       = '0;
				esc_d       = 1'b0;
			end
			sefd_pkg::PH_HEADER, sefd_pkg::PH_DATA: begin
				if (rx_byte == sefd_pkg::ESC_BYTE) begin
					esc_d = 1'b1;
				end else if (!esc_q && rx_byte == sefd_pkg::SYNC_BYTE) begin
					// unescaped sync inside a frame
					res_valid       = 1'b1;
					push_res.status = sefd_pkg::ST_STRAY;
					phase_d         = sefd_pkg::PH_HUNT;
					count_d         = '0;
					remaining_d     = '0;
					sum_d           = '0;
					esc_d           = 1'b0;
				end else begin
					res_valid          = 1'b1;
					push_res.kind      = sefd_pkg::KIND_DATA;
					push_res.data_byte = dec;
					push_res.sum_value = sum_new;
					esc_d              = 1'b0;
					sum_d              = sum_new;
					count_d            = count_new;
					if (phase_q == sefd_pkg::PH_HEADER) begin
						if (count_new >= sefd_pkg::HEADER_LEN) begin
							remaining_d = dec;
							phase_d     = (dec == 8'd0) ? sefd_pkg::PH_CHECK
							                            : sefd_pkg::PH_DATA;
						end
					end else begin
						remaining_d = rem_dec;
						if (rem_dec == 8'd0) begin
							phase_d = sefd_pkg::PH_CHECK;
						end
					end
				end
			end
			default: begin
				phase_d     = sefd_pkg::PH_HUNT;
				count_d     = '0;
				remaining_d = '0;
				sum_d       = '0;
				esc_d       = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sefd_pkg::PH_HUNT;
			count_q     <= '0;
			remaining_q <= '0;
			sum_q       <= '0;
			esc_q       <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			remaining_q <= remaining_d;
			sum_q       <= sum_d;
			esc_q       <= esc_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
			hunt_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sefd_pkg::CFG_CHECKSUM_STRICT: strict_q <= cfg_data;
				sefd_pkg::CFG_SYNC_HUNT:       hunt_q   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sefd_queue.sv =====
// small result queue between front and back, built from flip-flops
// depends on sefd_pkg
`default_nettype none

module sefd_queue #(
	parameter int unsigned Depth = sefd_pkg::QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  sefd_pkg::res_t      push_res,
	input  wire                 pop,
	output sefd_pkg::res_t      head,
	output sefd_pkg::q_stat_t   q_stat
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	sefd_pkg::res_t  mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign q_stat.full  = (cnt_q == CntW'(Depth));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sefd_back.sv =====
// back part: drains the result queue into the output register
// depends on sefd_pkg
`default_nettype none

module sefd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sefd_pkg::q_stat_t   q_stat,
	input  sefd_pkg::res_t      head,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output sefd_pkg::res_t      out_res
);

	logic           out_valid_q;
	sefd_pkg::res_t out_res_q;

	// load when the register is empty or being drained this cycle
	assign pop       = !q_stat.empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q <= head;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sefd_checker.sv =====
// port-level checker for the sync/escape frame decoder, with its bind
// depends on sefd_pkg and sync_escape_frame_decoder
`default_nettype none

module sefd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire        kind,
	input wire [7:0]  data_byte,
	input wire [8:0]  position,
	input wire [2:0]  status,
	input wire [7:0]  sum_value
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// decoded bytes always carry ok status
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sefd_pkg::KIND_DATA |-> status == sefd_pkg::ST_OK)
		else $error("decoded byte with non-ok status");

	// no-sync reports carry zero position and sum
	a_nosync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == sefd_pkg::ST_NOSYNC |->
			kind == sefd_pkg::KIND_STATUS && position == 9'd0 && sum_value == 8'd0)
		else $error("bad no-sync report");

	// a stray sync report carries the sync byte itself
	a_stray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == sefd_pkg::ST_STRAY |->
			kind == sefd_pkg::KIND_STATUS && data_byte == sefd_pkg::SYNC_BYTE)
		else $error("bad stray sync report");

	// a frame never holds more than header plus 255 data bytes
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sefd_pkg::KIND_DATA |-> position <= 9'd257)
		else $error("position out of range");

endmodule

bind sync_escape_frame_decoder sefd_checker u_sefd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.kind     (kind),
	.data_byte(data_byte),
	.position (position),
	.status   (status),
	.sum_value(sum_value)
);

`default_nettype wire
